// File: sv/cstc_pkg.sv
// Package: shared types and constants of the call stack trace compressor.
package cstc_pkg;

  typedef enum logic [1:0] {
    KIND_PUSH   = 2'd0,
    KIND_POP    = 2'd1,
    KIND_CHIP   = 2'd2,
    KIND_SAMPLE = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    REQ_PUSH   = 3'd0,
    REQ_POP    = 3'd1,
    REQ_CHIP   = 3'd2,
    REQ_SAMPLE = 3'd3,
    REQ_READ   = 3'd4
  } req_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_NO_SAMPLE = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TAIL_RD,
    S_PREV_RD,
    S_WR_DECIDE,
    S_WR_RESULT,
    S_HEAD_RD,
    S_HEAD_WAIT,
    S_HEAD_DO,
    S_RD_FINISH,
    S_HDR_OUT,
    S_FRAME_RD,
    S_FRAME_OUT
  } state_e;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] func_id;
    logic [47:0] instr_ptr;
    logic [31:0] tick_stamp;
    logic [31:0] sample_repeat;
  } req_t;

  typedef struct packed {
    logic        accepted;
    logic [2:0]  status_code;
    logic [31:0] out_ticks;
    logic [31:0] out_repeat;
    logic [5:0]  shadow_depth;
    logic [5:0]  prefix_kept;
    logic [47:0] changed_ip;
    logic [31:0] frame_func;
    logic [47:0] frame_ip;
    logic        is_frame;
    logic [7:0]  pending_samples;
    logic        last_result;
  } rsp_t;

  // tag word: kind in [1:0], value in [33:2]
  typedef struct packed {
    logic [31:0] val;
    logic [1:0]  kind;
  } tag_t;

  typedef struct packed {
    tag_t        tag;
    logic [63:0] pay;
  } entry_t;

endpackage

// File: sv/call_stack_trace_compressor_core.sv
// Top level: request sequencer of the call stack trace compressor.
// Writer request, one at a time: tail read, prior read, decide, sample finish, result word.
// Read: head read, wait and do steps per event up to the sample, finish and header steps,
// then frame read and output per changed frame; one queue read port sets the pace.
// Reset: queue holds one no-op entry, written in the first cycle after reset (not ready
// until then), all counters zero; shadow stack contents are undefined until written.
module call_stack_trace_compressor_core #(
  parameter int QUEUE_DEPTH = 128,
  parameter int STACK_DEPTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  cstc_pkg::req_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output cstc_pkg::rsp_t   out_data_o
);
  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = $clog2(STACK_DEPTH);
  localparam int LW = 6;
  localparam int SQW = FW;

  cstc_pkg::state_e state_q, state_d;
  cstc_pkg::req_t   req_q, req_d;
  logic [AW-1:0] head_q, head_d;
  logic [FW-1:0] fill_q, fill_d;
  cstc_pkg::kind_e first_q, first_d;
  logic [LW-1:0] gpush_q, gpush_d, wlev_q, wlev_d, slev_q, slev_d;
  logic [LW-1:0] prefix_q, prefix_d, fidx_q, fidx_d;
  logic [SQW-1:0] samp_q, samp_d;
  cstc_pkg::entry_t tail_q, tail_d;
  logic [31:0] tk_q, tk_d, rp_q, rp_d;
  logic [47:0] cip_q, cip_d;
  cstc_pkg::rsp_t rsp_q, rsp_d;
  logic out_v_q, out_v_d;

  logic q_we;
  logic [AW-1:0] q_waddr, q_raddr;
  cstc_pkg::entry_t q_wdata, q_rdata;
  logic s_we;
  logic [SW-1:0] s_waddr, s_raddr;
  logic [79:0] s_wdata, s_rdata;

  cstc_queue_mem #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_qmem (
    .clk_i, .we_i(q_we), .waddr_i(q_waddr), .wdata_i(q_wdata),
    .raddr_i(q_raddr), .rdata_o(q_rdata));

  cstc_shadow_mem #(.STACK_DEPTH(STACK_DEPTH)) u_smem (
    .clk_i, .we_i(s_we), .waddr_i(s_waddr), .wdata_i(s_wdata),
    .raddr_i(s_raddr), .rdata_o(s_rdata));

  function automatic logic [AW-1:0] slot_of(logic [AW-1:0] h, logic [FW-1:0] off);
    logic [FW:0] s;
    s = {{(FW+1-AW){1'b0}}, h} + {1'b0, off};
    if (s >= (FW+1)'(QUEUE_DEPTH)) s = s - (FW+1)'(QUEUE_DEPTH);
    return s[AW-1:0];
  endfunction

  function automatic cstc_pkg::entry_t mk(cstc_pkg::kind_e k, logic [31:0] v,
                                         logic [63:0] p);
    cstc_pkg::entry_t e;
    e.tag.kind = k;
    e.tag.val  = v;
    e.pay      = p;
    return e;
  endfunction

  logic [7:0] pend_sat;
  logic tail_nop;
  always_comb begin
    pend_sat = (samp_q > SQW'(255)) ? 8'd255 : 8'(samp_q);
    tail_nop = (tail_q.tag.kind == cstc_pkg::KIND_POP) && (tail_q.tag.val == '0);
  end

  assign in_ready_o  = (state_q == cstc_pkg::S_IDLE) && init_q;
  assign out_valid_o = out_v_q;
  assign out_data_o  = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cstc_pkg::S_IDLE;
      head_q  <= '0;
      fill_q  <= FW'(1);
      first_q <= cstc_pkg::KIND_POP;
      gpush_q <= '0;
      wlev_q  <= '0;
      slev_q  <= '0;
      samp_q  <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      fill_q  <= fill_d;
      first_q <= first_d;
      gpush_q <= gpush_d;
      wlev_q  <= wlev_d;
      slev_q  <= slev_d;
      samp_q  <= samp_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    tail_q   <= tail_d;
    tk_q     <= tk_d;
    rp_q     <= rp_d;
    cip_q    <= cip_d;
    rsp_q    <= rsp_d;
    prefix_q <= prefix_d;
    fidx_q   <= fidx_d;
  end

  logic ws_mem;  // reset queue entry 0 is modelled by writing on first use
  // The no-op at reset: slot 0 must read as no-op; handled by init flag below.
  logic init_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) init_q <= 1'b0;
    else if (ws_mem) init_q <= 1'b1;
  end

  always_comb begin
    cstc_pkg::entry_t e;
    logic [LW-1:0] nl;
    logic [2:0] st;
    state_d = state_q;
    req_d = req_q;
    head_d = head_q; fill_d = fill_q; first_d = first_q;
    gpush_d = gpush_q; wlev_d = wlev_q; slev_d = slev_q; samp_d = samp_q;
    tail_d = tail_q; tk_d = tk_q; rp_d = rp_q; cip_d = cip_q;
    prefix_d = prefix_q; fidx_d = fidx_q;
    rsp_d = rsp_q; out_v_d = out_v_q;
    q_we = 1'b0; q_waddr = head_q; q_wdata = mk(cstc_pkg::KIND_POP, '0, '0);
    q_raddr = slot_of(head_q, fill_q - FW'(1));
    s_we = 1'b0; s_waddr = '0; s_wdata = '0; s_raddr = fidx_q[SW-1:0];
    ws_mem = 1'b0;
    e = mk(cstc_pkg::KIND_POP, '0, '0);
    nl = '0; st = cstc_pkg::ST_OK;

    if (out_v_q && out_ready_i) out_v_d = 1'b0;

    unique case (state_q)
      cstc_pkg::S_IDLE: begin
        if (!init_q) begin
          q_we = 1'b1; q_waddr = '0; ws_mem = 1'b1;
        end else if (in_valid_i) begin
          req_d = in_data_i;
          if (in_data_i.req_type == cstc_pkg::REQ_READ) begin
            if (samp_q == '0) begin
              rsp_d = '0;
              rsp_d.status_code = cstc_pkg::ST_NO_SAMPLE;
              rsp_d.shadow_depth = wlev_q;
              rsp_d.pending_samples = pend_sat;
              rsp_d.last_result = 1'b1;
              out_v_d = 1'b1;
              state_d = cstc_pkg::S_WR_RESULT;
            end else begin
              prefix_d = slev_q;
              tk_d = '0; rp_d = '0; cip_d = '0;
              state_d = cstc_pkg::S_HEAD_RD;
            end
          end else begin
            state_d = cstc_pkg::S_TAIL_RD;
          end
        end
      end
      cstc_pkg::S_TAIL_RD: begin
        tail_d = q_rdata;
        q_raddr = slot_of(head_q, fill_q - FW'(2));
        state_d = cstc_pkg::S_PREV_RD;
      end
      cstc_pkg::S_PREV_RD: begin
        // keep the entry before the tail on the read port for the decide step
        q_raddr = slot_of(head_q, fill_q - FW'(2));
        state_d = cstc_pkg::S_WR_DECIDE;
      end
      cstc_pkg::S_WR_DECIDE: begin
        // q_rdata holds the entry before the tail here
        q_waddr = slot_of(head_q, fill_q - FW'(1));
        unique case (req_q.req_type)
          cstc_pkg::REQ_PUSH: begin
            if (wlev_q >= LW'(STACK_DEPTH)) st = cstc_pkg::ST_OVERFLOW;
            else if (tail_nop) begin
              q_we = 1'b1; q_wdata = mk(cstc_pkg::KIND_PUSH, req_q.func_id, '0);
              first_d = cstc_pkg::KIND_PUSH;
            end else if (fill_q >= FW'(QUEUE_DEPTH)) st = cstc_pkg::ST_FULL;
            else begin
              q_we = 1'b1; q_waddr = slot_of(head_q, fill_q);
              q_wdata = mk(cstc_pkg::KIND_PUSH, req_q.func_id, '0);
              fill_d = fill_q + FW'(1);
            end
            if (st == cstc_pkg::ST_OK) begin
              wlev_d = wlev_q + LW'(1); gpush_d = gpush_q + LW'(1);
            end
          end
          cstc_pkg::REQ_POP: begin
            if (wlev_q == '0) st = cstc_pkg::ST_EMPTY;
            else begin
              unique case (tail_q.tag.kind)
                cstc_pkg::KIND_PUSH: begin
                  if ((gpush_q == LW'(1) && first_q == cstc_pkg::KIND_PUSH)
                      || fill_q == FW'(1)) begin
                    q_we = 1'b1; first_d = cstc_pkg::KIND_POP;
                  end else fill_d = fill_q - FW'(1);
                  if (gpush_q != '0) gpush_d = gpush_q - LW'(1);
                end
                cstc_pkg::KIND_POP: begin
                  q_we = 1'b1;
                  q_wdata = mk(cstc_pkg::KIND_POP, tail_q.tag.val + 32'd1, tail_q.pay);
                end
                cstc_pkg::KIND_CHIP: begin
                  if (first_q != cstc_pkg::KIND_CHIP && fill_q > FW'(1)
                      && q_rdata.tag.kind == cstc_pkg::KIND_POP) begin
                    fill_d = fill_q - FW'(1);
                    q_we = 1'b1; q_waddr = slot_of(head_q, fill_q - FW'(2));
                    q_wdata = mk(cstc_pkg::KIND_POP, q_rdata.tag.val + 32'd1,
                                 q_rdata.pay);
                  end else begin
                    q_we = 1'b1; q_wdata = mk(cstc_pkg::KIND_POP, 32'd1, '0);
                    first_d = cstc_pkg::KIND_POP;
                  end
                end
                default: ;
              endcase
              wlev_d = wlev_q - LW'(1);
            end
          end
          cstc_pkg::REQ_CHIP: begin
            if (wlev_q == '0) st = cstc_pkg::ST_EMPTY;
            else if (tail_nop) begin
              q_we = 1'b1;
              q_wdata = mk(cstc_pkg::KIND_CHIP, '0, {16'd0, req_q.instr_ptr});
              first_d = cstc_pkg::KIND_CHIP;
            end else if (tail_q.tag.kind == cstc_pkg::KIND_PUSH
                         || tail_q.tag.kind == cstc_pkg::KIND_CHIP) begin
              q_we = 1'b1;
              q_wdata = tail_q; q_wdata.pay = {16'd0, req_q.instr_ptr};
            end else if (fill_q >= FW'(QUEUE_DEPTH)) st = cstc_pkg::ST_FULL;
            else begin
              q_we = 1'b1; q_waddr = slot_of(head_q, fill_q);
              q_wdata = mk(cstc_pkg::KIND_CHIP, '0, {16'd0, req_q.instr_ptr});
              fill_d = fill_q + FW'(1);
            end
          end
          cstc_pkg::REQ_SAMPLE: begin
            if (tail_nop) begin
              if (fill_q + FW'(1) > FW'(QUEUE_DEPTH)) st = cstc_pkg::ST_FULL;
              else begin
                q_we = 1'b1;
                q_wdata = mk(cstc_pkg::KIND_SAMPLE, '0,
                             {req_q.sample_repeat, req_q.tick_stamp});
                fill_d = fill_q;
              end
            end else if ({1'b0, fill_q} + (FW+1)'(2) > (FW+1)'(QUEUE_DEPTH))
              st = cstc_pkg::ST_FULL;
            else begin
              q_we = 1'b1; q_waddr = slot_of(head_q, fill_q);
              q_wdata = mk(cstc_pkg::KIND_SAMPLE, '0,
                           {req_q.sample_repeat, req_q.tick_stamp});
              fill_d = fill_q + FW'(1);
            end
            if (st == cstc_pkg::ST_OK) begin
              first_d = cstc_pkg::KIND_POP; gpush_d = '0;
              samp_d = samp_q + SQW'(1);
              state_d = cstc_pkg::S_RD_FINISH;  // append the trailing no-op
            end
          end
          default: st = cstc_pkg::ST_OK;
        endcase
        rsp_d = '0;
        rsp_d.accepted = (st == cstc_pkg::ST_OK) &&
                         (req_q.req_type <= cstc_pkg::REQ_SAMPLE);
        rsp_d.status_code = st;
        rsp_d.shadow_depth = wlev_d;
        rsp_d.pending_samples = (samp_d > SQW'(255)) ? 8'd255 : 8'(samp_d);
        rsp_d.last_result = 1'b1;
        if (state_d != cstc_pkg::S_RD_FINISH) begin
          out_v_d = 1'b1;
          state_d = cstc_pkg::S_WR_RESULT;
        end
      end
      cstc_pkg::S_WR_RESULT: begin
        if (!out_v_q) state_d = cstc_pkg::S_IDLE;
      end
      cstc_pkg::S_HEAD_RD: begin
        q_raddr = head_q;
        state_d = cstc_pkg::S_HEAD_WAIT;
      end
      cstc_pkg::S_HEAD_WAIT: begin
        q_raddr = head_q;
        // top frame, for an ip change that keeps its function id
        s_raddr = SW'(slev_q - LW'(1));
        state_d = cstc_pkg::S_HEAD_DO;
      end
      cstc_pkg::S_HEAD_DO: begin
        e = q_rdata;
        head_d = slot_of(head_q, FW'(1));
        fill_d = fill_q - FW'(1);
        state_d = (fill_d == '0) ? cstc_pkg::S_RD_FINISH : cstc_pkg::S_HEAD_RD;
        unique case (e.tag.kind)
          cstc_pkg::KIND_PUSH: begin
            if (slev_q < LW'(STACK_DEPTH)) begin
              s_we = 1'b1; s_waddr = slev_q[SW-1:0];
              s_wdata = {e.tag.val, e.pay[47:0]};
              slev_d = slev_q + LW'(1);
            end
          end
          cstc_pkg::KIND_POP: begin
            nl = (e.tag.val >= {26'd0, slev_q}) ? '0 : slev_q - e.tag.val[LW-1:0];
            slev_d = nl;
            if (nl < prefix_q) prefix_d = nl;
          end
          cstc_pkg::KIND_CHIP: begin
            cip_d = e.pay[47:0];
            if (slev_q != '0) begin
              // rewrite ip only; func comes from the word read in the wait step
              s_we = 1'b1; s_waddr = SW'(slev_q - LW'(1));
              s_wdata = {s_rdata[79:48], e.pay[47:0]};
            end
          end
          default: begin
            tk_d = e.pay[31:0]; rp_d = e.pay[63:32];
            samp_d = samp_q - SQW'(1);
            state_d = cstc_pkg::S_RD_FINISH;
          end
        endcase
      end
      cstc_pkg::S_RD_FINISH: begin
        if (fill_q == '0 || req_q.req_type == cstc_pkg::REQ_SAMPLE) begin
          q_we = 1'b1;
          q_waddr = slot_of(head_q, fill_q);
          q_wdata = mk(cstc_pkg::KIND_POP, '0, '0);
          fill_d = fill_q + FW'(1);
        end
        if (req_q.req_type == cstc_pkg::REQ_SAMPLE) begin
          out_v_d = 1'b1;
          state_d = cstc_pkg::S_WR_RESULT;
        end else begin
          fidx_d = prefix_q;
          state_d = cstc_pkg::S_HDR_OUT;
        end
      end
      cstc_pkg::S_HDR_OUT: begin
        if (!out_v_q) begin
          rsp_d = '0;
          rsp_d.accepted = 1'b1;
          rsp_d.out_ticks = tk_q; rsp_d.out_repeat = rp_q;
          rsp_d.shadow_depth = slev_q; rsp_d.prefix_kept = prefix_q;
          rsp_d.changed_ip = cip_q;
          rsp_d.pending_samples = pend_sat;
          rsp_d.last_result = (prefix_q >= slev_q);
          out_v_d = 1'b1;
          state_d = (prefix_q >= slev_q) ? cstc_pkg::S_WR_RESULT
                                         : cstc_pkg::S_FRAME_RD;
        end
      end
      cstc_pkg::S_FRAME_RD: begin
        state_d = cstc_pkg::S_FRAME_OUT;
      end
      cstc_pkg::S_FRAME_OUT: begin
        if (!out_v_q) begin
          rsp_d.frame_func = s_rdata[79:48];
          rsp_d.frame_ip = s_rdata[47:0];
          rsp_d.is_frame = 1'b1;
          rsp_d.last_result = (fidx_q + LW'(1) == slev_q);
          out_v_d = 1'b1;
          fidx_d = fidx_q + LW'(1);
          state_d = rsp_d.last_result ? cstc_pkg::S_WR_RESULT
                                      : cstc_pkg::S_FRAME_RD;
        end
      end
      default: state_d = cstc_pkg::S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(QUEUE_DEPTH)) else $error("queue fill over capacity");
  a_levels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wlev_q <= LW'(STACK_DEPTH)) && (slev_q <= LW'(STACK_DEPTH)))
    else $error("stack level over depth");
  a_busy_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> !in_ready_o) else $error("ready while a word waits");
  a_frame_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && rsp_q.is_frame) |-> (rsp_q.prefix_kept < rsp_q.shadow_depth))
    else $error("frame word outside changed range");
`endif
endmodule

// File: sv/cstc_queue_mem.sv
// Event queue storage: one write port, one registered read port.
module cstc_queue_mem #(
  parameter int QUEUE_DEPTH = 128,
  localparam int AW = $clog2(QUEUE_DEPTH)
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AW-1:0]       waddr_i,
  input  cstc_pkg::entry_t    wdata_i,
  input  logic [AW-1:0]       raddr_i,
  output cstc_pkg::entry_t    rdata_o
);
  cstc_pkg::entry_t mem_q [QUEUE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: sv/cstc_shadow_mem.sv
// Shadow call stack storage: one write port, one registered read port.
module cstc_shadow_mem #(
  parameter int STACK_DEPTH = 32,
  localparam int SW = $clog2(STACK_DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [SW-1:0] waddr_i,
  input  logic [79:0]   wdata_i,
  input  logic [SW-1:0] raddr_i,
  output logic [79:0]   rdata_o
);
  logic [79:0] mem_q [STACK_DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
